/* rtl/mecanum_wheel_mixer_defines.svh */
// assertion macros for the mecanum wheel mixer
// expects i_clk and i_rst_n in the scope of each use
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mwm check failed");

// next-cycle implication, disabled while in reset
`define MWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mwm check failed");

`endif

/* rtl/mwm_pkg.sv */
// shared widths, command type and helpers for the mecanum wheel mixer
// no dependencies
`default_nettype none

package mwm_pkg;

    localparam int SPD_W       = 16;
    localparam int MAX_W       = 15;
    localparam int SUM_W       = 18;
    localparam int MAG_W       = SUM_W - 1;
    localparam int PROD_W      = MAG_W + MAX_W;
    localparam int QUOT_W      = MAX_W;
    localparam int NUM_WHEELS  = 4;
    localparam int QUEUE_DEPTH = 2;  // keep a power of two, pointers wrap naturally
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAX_W-1:0] MAX_SPEED_RESET = MAX_W'(8000);

    localparam int WHEEL_LF = 0;
    localparam int WHEEL_RF = 1;
    localparam int WHEEL_LB = 2;
    localparam int WHEEL_RB = 3;

    typedef logic signed [SPD_W-1:0] t_speed;
    typedef logic [MAX_W-1:0]        t_max;
    typedef logic [SUM_W-1:0]        t_sum;
    typedef logic [MAG_W-1:0]        t_mag;

    // classified command handed from the front to the back
    typedef struct packed {
        t_sum [NUM_WHEELS-1:0] sum;
        t_mag                  largest;
        logic                  scaled;
    } t_cmd;

    function automatic t_mag mag_of(input t_sum s);
        t_sum neg;
        neg = -s;
        return s[SUM_W-1] ? neg[MAG_W-1:0] : s[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/mwm_front.sv */
// front end: takes commands, clamps, forms wheel sums, finds the largest magnitude
// and flags whether scaling is needed; depends on mwm_pkg
`default_nettype none

module mwm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mwm_pkg::t_max  i_max,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mwm_pkg::t_speed i_vel_forward,
    input  wire mwm_pkg::t_speed i_vel_sideways,
    input  wire mwm_pkg::t_speed i_rot_rate,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready,
    output mwm_pkg::t_cmd       o_cmd
);
    import mwm_pkg::*;

    localparam int CLAMP_W = SPD_W + 1;

    logic             r_s1_valid;
    t_sum [NUM_WHEELS-1:0] r_s1_sum;
    logic             r_s2_valid;
    t_cmd             r_s2_cmd;

    t_sum [NUM_WHEELS-1:0] n_s1_sum;
    t_cmd             n_s2_cmd;
    logic             adv;

    logic signed [CLAMP_W-1:0] vx;
    logic signed [CLAMP_W-1:0] vy;
    logic signed [SUM_W-1:0]   vx_e;
    logic signed [SUM_W-1:0]   vy_e;
    logic signed [SUM_W-1:0]   w_e;
    t_mag [NUM_WHEELS-1:0]     mags;
    t_mag                      max_a;
    t_mag                      max_b;
    t_mag                      largest;

    function automatic logic signed [CLAMP_W-1:0] clamp_sym(
        input t_speed v,
        input t_max   m
    );
        logic signed [CLAMP_W-1:0] ve;
        logic signed [CLAMP_W-1:0] me;
        ve = CLAMP_W'(v);
        me = $signed({{(CLAMP_W-MAX_W){1'b0}}, m});
        if (ve > me) begin
            return me;
        end else if (ve < -me) begin
            return -me;
        end
        return ve;
    endfunction

    // stage 1 moves whenever stage 2 can move
    assign adv        = !r_s2_valid || i_cmd_ready;
    assign o_in_ready = adv;

    always_comb begin
        vx   = clamp_sym(i_vel_forward, i_max);
        vy   = clamp_sym(i_vel_sideways, i_max);
        vx_e = SUM_W'(vx);
        vy_e = SUM_W'(vy);
        w_e  = SUM_W'(i_rot_rate);
        n_s1_sum[WHEEL_LF] = vx_e + vy_e + w_e;
        n_s1_sum[WHEEL_RF] = vx_e - vy_e - w_e;
        n_s1_sum[WHEEL_LB] = vx_e - vy_e + w_e;
        n_s1_sum[WHEEL_RB] = vx_e + vy_e - w_e;
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            mags[i] = mag_of(r_s1_sum[i]);
        end
        max_a   = (mags[WHEEL_LF] > mags[WHEEL_RF]) ? mags[WHEEL_LF] : mags[WHEEL_RF];
        max_b   = (mags[WHEEL_LB] > mags[WHEEL_RB]) ? mags[WHEEL_LB] : mags[WHEEL_RB];
        largest = (max_a > max_b) ? max_a : max_b;
        n_s2_cmd.sum     = r_s1_sum;
        n_s2_cmd.largest = largest;
        n_s2_cmd.scaled  = largest > MAG_W'(i_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
        end
        if (adv) begin
            r_s1_sum <= n_s1_sum;
            r_s2_cmd <= n_s2_cmd;
        end
    end

    assign o_cmd_valid = r_s2_valid;
    assign o_cmd       = r_s2_cmd;

endmodule

`default_nettype wire

/* rtl/mwm_queue.sv */
// small first-word-fall-through queue of classified commands between front and back
// depends on mwm_pkg
`default_nettype none

module mwm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire mwm_pkg::t_cmd i_push_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output mwm_pkg::t_cmd      o_pop_cmd
);
    import mwm_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/mwm_back.sv */
// back end: per wheel multiply by the maximum, then a pipelined restoring divide
// by the largest magnitude, one quotient bit per stage; depends on mwm_pkg
`default_nettype none

module mwm_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mwm_pkg::t_max i_max,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire mwm_pkg::t_cmd i_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mwm_pkg::t_speed    o_wheel_lf,
    output mwm_pkg::t_speed    o_wheel_rf,
    output mwm_pkg::t_speed    o_wheel_lb,
    output mwm_pkg::t_speed    o_wheel_rb,
    output logic               o_was_scaled
);
    import mwm_pkg::*;

    localparam int STEPS = QUOT_W;

    logic                    r_valid  [STEPS+1];
    logic                    r_scaled [STEPS+1];
    t_mag                    r_div    [STEPS+1];
    logic [NUM_WHEELS-1:0]   r_neg    [STEPS+1];
    logic [PROD_W-1:0]       r_work   [STEPS+1][NUM_WHEELS];

    logic                    r_out_valid;
    logic                    r_out_scaled;
    t_speed                  r_wheel  [NUM_WHEELS];

    logic                    en;
    t_mag                    n_div0;
    logic [NUM_WHEELS-1:0]   n_neg0;
    logic [PROD_W-1:0]       n_work   [STEPS+1][NUM_WHEELS];
    t_speed                  n_wheel  [NUM_WHEELS];

    // whole back pipeline advances unless the output holds an untaken transaction
    assign en          = !r_out_valid || i_out_ready;
    assign o_cmd_ready = en;

    // unscaled wheels go through as |s| * 1 / 1
    // work word is {remainder, remaining dividend bits / quotient bits}
    always_comb begin
        t_max             mult;
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic             ge;
        logic [MAG_W-1:0] rem;
        mult   = i_cmd.scaled ? i_max : MAX_W'(1);
        n_div0 = i_cmd.scaled ? i_cmd.largest : MAG_W'(1);
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_neg0[l]     = i_cmd.sum[l][SUM_W-1];
            n_work[0][l]  = PROD_W'(mag_of(i_cmd.sum[l])) * PROD_W'(mult);
        end
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        rem   = '0;
        for (int k = 1; k <= STEPS; k++) begin
            for (int l = 0; l < NUM_WHEELS; l++) begin
                trial = {r_work[k-1][l][PROD_W-1:QUOT_W], r_work[k-1][l][QUOT_W-1]};
                diff  = trial - {1'b0, r_div[k-1]};
                ge    = trial >= {1'b0, r_div[k-1]};
                rem   = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                n_work[k][l] = {rem, r_work[k-1][l][QUOT_W-2:0], ge};
            end
        end
    end

    always_comb begin
        logic [SPD_W-1:0] q;
        q = '0;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            q          = {1'b0, r_work[STEPS][l][QUOT_W-1:0]};
            n_wheel[l] = r_neg[STEPS][l] ? -$signed(q) : $signed(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid[0] <= i_cmd_valid;
            for (int k = 1; k <= STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            r_out_valid <= r_valid[STEPS];
        end
        if (en) begin
            r_scaled[0] <= i_cmd.scaled;
            r_div[0]    <= n_div0;
            r_neg[0]    <= n_neg0;
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r_work[0][l] <= n_work[0][l];
            end
            for (int k = 1; k <= STEPS; k++) begin
                r_scaled[k] <= r_scaled[k-1];
                r_div[k]    <= r_div[k-1];
                r_neg[k]    <= r_neg[k-1];
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    r_work[k][l] <= n_work[k][l];
                end
            end
            r_out_scaled <= r_scaled[STEPS];
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r_wheel[l] <= n_wheel[l];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_was_scaled = r_out_scaled;
    assign o_wheel_lf   = r_wheel[WHEEL_LF];
    assign o_wheel_rf   = r_wheel[WHEEL_RF];
    assign o_wheel_lb   = r_wheel[WHEEL_LB];
    assign o_wheel_rb   = r_wheel[WHEEL_RB];

endmodule

`default_nettype wire

/* rtl/mecanum_wheel_mixer.sv */
// result path: front stage 1 loads at the transaction, then stage 2, the queue,
// the multiply stage, 15 divide stages and the output register
// throughput: one command per cycle while the output is not stalled; each divide stage resolves one quotient bit
// a 2-entry queue lets the front take a few more transactions while the back is stalled
// reset: synchronous active low, clears all valid state and sets max speed to 8000
// top level of the mecanum wheel mixer; depends on mwm_pkg, mwm_front, mwm_queue, mwm_back
`default_nettype none

`include "mecanum_wheel_mixer_defines.svh"

module mecanum_wheel_mixer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire mwm_pkg::t_max   i_cfg_data,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire mwm_pkg::t_speed i_vel_forward,
    input  wire mwm_pkg::t_speed i_vel_sideways,
    input  wire mwm_pkg::t_speed i_rot_rate,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output mwm_pkg::t_speed      o_wheel_lf,
    output mwm_pkg::t_speed      o_wheel_rf,
    output mwm_pkg::t_speed      o_wheel_lb,
    output mwm_pkg::t_speed      o_wheel_rb,
    output logic                 o_was_scaled
);
    import mwm_pkg::*;

    t_max r_max;

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic back_valid;
    logic back_ready;
    t_cmd back_cmd;

    logic signed [SPD_W:0] max_pos;
    logic signed [SPD_W:0] max_neg;
    logic [NUM_WHEELS-1:0] wheel_ok;

    function automatic logic in_bound(
        input t_speed                v,
        input logic signed [SPD_W:0] hi,
        input logic signed [SPD_W:0] lo
    );
        logic signed [SPD_W:0] ve;
        ve = (SPD_W+1)'(v);
        return (ve <= hi) && (ve >= lo);
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_SPEED_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    mwm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max          (r_max),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vel_forward  (i_vel_forward),
        .i_vel_sideways (i_vel_sideways),
        .i_rot_rate     (i_rot_rate),
        .o_cmd_valid    (front_valid),
        .i_cmd_ready    (front_ready),
        .o_cmd          (front_cmd)
    );

    mwm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (back_cmd)
    );

    mwm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max        (r_max),
        .i_cmd_valid  (back_valid),
        .o_cmd_ready  (back_ready),
        .i_cmd        (back_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_wheel_lf   (o_wheel_lf),
        .o_wheel_rf   (o_wheel_rf),
        .o_wheel_lb   (o_wheel_lb),
        .o_wheel_rb   (o_wheel_rb),
        .o_was_scaled (o_was_scaled)
    );

    // no wheel result may exceed the configured maximum in magnitude
    assign max_pos = $signed({2'b00, r_max});
    assign max_neg = -max_pos;

    assign wheel_ok[WHEEL_LF] = in_bound(o_wheel_lf, max_pos, max_neg);
    assign wheel_ok[WHEEL_RF] = in_bound(o_wheel_rf, max_pos, max_neg);
    assign wheel_ok[WHEEL_LB] = in_bound(o_wheel_lb, max_pos, max_neg);
    assign wheel_ok[WHEEL_RB] = in_bound(o_wheel_rb, max_pos, max_neg);

    `MWM_ASSERT_NOW(a_front_bound, o_out_valid, wheel_ok[WHEEL_LF] && wheel_ok[WHEEL_RF])
    `MWM_ASSERT_NOW(a_back_bound, o_out_valid, wheel_ok[WHEEL_LB] && wheel_ok[WHEEL_RB])
    `MWM_ASSERT_NEXT(a_cfg_write, i_cfg_valid && o_cfg_ready, r_max == $past(i_cfg_data))

endmodule

`default_nettype wire
